/* design/cna_pkg.sv */
package cna_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QB = 32;    // quotient and root bits, one per iteration stage
  localparam int SQ_W = 36;  // square root partial remainder width

  localparam logic [2:0] K_ADD = 3'd0;
  localparam logic [2:0] K_SUB = 3'd1;
  localparam logic [2:0] K_MUL = 3'd2;
  localparam logic [2:0] K_DIV = 3'd3;
  localparam logic [2:0] K_MOD = 3'd4;
  localparam logic [2:0] K_CONJ = 3'd5;
  localparam logic [2:0] K_CMP = 3'd6;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic eq;
    logic ovf;
  } fin_t;

  typedef struct packed {
    logic [2:0] kind;
    fin_t fin;
    logic re_neg;
    logic im_neg;
    logic big_re;
    logic big_im;
    logic dz;
  } pay_t;

  // clamp a sign and magnitude to 32 bits, msb is the overflow flag
  function automatic logic [32:0] sat_sm(input logic neg, input logic [63:0] mag);
    logic ovf;
    logic [31:0] v;
    if (neg) begin
      ovf = mag > 64'h0000_0000_8000_0000;
      v = ovf ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    end else begin
      ovf = mag > 64'h0000_0000_7FFF_FFFF;
      v = ovf ? 32'h7FFF_FFFF : mag[31:0];
    end
    return {ovf, v};
  endfunction

  // clamp a 33-bit two's complement sum to 32 bits, msb is the overflow flag
  function automatic logic [32:0] sat_33(input logic [32:0] s);
    logic ovf;
    logic [31:0] v;
    ovf = s[32] ^ s[31];
    if (ovf) begin
      v = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      v = s[31:0];
    end
    return {ovf, v};
  endfunction

endpackage

/* design/complex_number_alu_core.sv */
// complex arithmetic unit on signed Q16.16 operands
// input: pulse start with in_kind and the four operand parts; busy is always
//   low, so an item can be started in every cycle
// output: out_valid is high for one cycle with the result fields; the
//   receiver cannot hold results off and none is needed
// order: every operation takes the same path through the pipeline, so
//   results leave in start order
// throughput: one item per cycle; products and sums take three stages, then
//   two restoring dividers and a square root run side by side, one quotient
//   and one root bit per stage over 32 stages, then a saturation stage
// add, subtract, conjugate and compare finish in the first stage and ride
// along with the rest
// reset: synchronous active low rst_n clears every valid bit; items in
//   flight are dropped and no result appears until a new start
module complex_number_alu_core import cna_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_kind,
  input  logic signed [31:0] in_a_real,
  input  logic signed [31:0] in_a_imag,
  input  logic signed [31:0] in_b_real,
  input  logic signed [31:0] in_b_imag,
  output logic               out_valid,
  output logic signed [31:0] out_res_real,
  output logic signed [31:0] out_res_imag,
  output logic               out_is_equal,
  output logic               out_div_zero,
  output logic               out_overflow
);

  assign busy = 1'b0;

  // stage 1: products and the simple operations
  logic               v1_r;
  logic [2:0]         kind1_r;
  fin_t               fin1_r;
  logic signed [63:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  fin_t               fin1_nxt;
  logic signed [31:0] sx, sy;
  logic [32:0]        s_re, s_im;

  assign sx = (in_kind == K_MOD) ? in_a_real : in_b_real;
  assign sy = (in_kind == K_MOD) ? in_a_imag : in_b_imag;

  always_comb begin
    fin1_nxt = '0;
    s_re = '0;
    s_im = '0;
    unique case (in_kind)
      K_ADD: begin
        s_re = sat_33({in_a_real[31], in_a_real} + {in_b_real[31], in_b_real});
        s_im = sat_33({in_a_imag[31], in_a_imag} + {in_b_imag[31], in_b_imag});
        fin1_nxt.re = s_re[31:0];
        fin1_nxt.im = s_im[31:0];
        fin1_nxt.ovf = s_re[32] | s_im[32];
      end
      K_SUB: begin
        s_re = sat_33({in_a_real[31], in_a_real} - {in_b_real[31], in_b_real});
        s_im = sat_33({in_a_imag[31], in_a_imag} - {in_b_imag[31], in_b_imag});
        fin1_nxt.re = s_re[31:0];
        fin1_nxt.im = s_im[31:0];
        fin1_nxt.ovf = s_re[32] | s_im[32];
      end
      K_CONJ: begin
        s_im = sat_33(33'd0 - {in_a_imag[31], in_a_imag});
        fin1_nxt.re = in_a_real;
        fin1_nxt.im = s_im[31:0];
        fin1_nxt.ovf = s_im[32];
      end
      K_CMP: begin
        fin1_nxt.eq = (in_a_real == in_b_real) && (in_a_imag == in_b_imag);
      end
      default: begin
        fin1_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start & ~busy;
    end
    kind1_r <= in_kind;
    fin1_r  <= fin1_nxt;
    p0_r    <= 64'(in_a_real) * 64'(in_b_real);
    p1_r    <= 64'(in_a_imag) * 64'(in_b_imag);
    p2_r    <= 64'(in_a_real) * 64'(in_b_imag);
    p3_r    <= 64'(in_a_imag) * 64'(in_b_real);
    p4_r    <= 64'(sx) * 64'(sx);
    p5_r    <= 64'(sy) * 64'(sy);
  end

  // stage 2: sums of products
  logic               v2_r;
  logic [2:0]         kind2_r;
  fin_t               fin2_r;
  logic signed [65:0] mre_r, mim_r, dre_r, dim_r;
  logic [63:0]        sq2_r;
  logic [65:0]        sq_sum;

  assign sq_sum = 66'(p4_r) + 66'(p5_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    kind2_r <= kind1_r;
    fin2_r  <= fin1_r;
    mre_r   <= 66'(p0_r) - 66'(p1_r);
    mim_r   <= 66'(p2_r) + 66'(p3_r);
    dre_r   <= 66'(p0_r) + 66'(p1_r);
    dim_r   <= 66'(p3_r) - 66'(p2_r);
    sq2_r   <= sq_sum[63:0];
  end

  // stage 3: sign and magnitude
  logic        v3_r;
  logic [2:0]  kind3_r;
  fin_t        fin3_r;
  logic [63:0] mre_mag_r, mim_mag_r, dre_mag_r, dim_mag_r, sq3_r;
  logic        mre_neg_r, mim_neg_r, dre_neg_r, dim_neg_r, dz3_r;
  logic [65:0] n_mre, n_mim, n_dre, n_dim;

  assign n_mre = -mre_r;
  assign n_mim = -mim_r;
  assign n_dre = -dre_r;
  assign n_dim = -dim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    kind3_r   <= kind2_r;
    fin3_r    <= fin2_r;
    mre_neg_r <= mre_r[65];
    mim_neg_r <= mim_r[65];
    dre_neg_r <= dre_r[65];
    dim_neg_r <= dim_r[65];
    mre_mag_r <= mre_r[65] ? n_mre[63:0] : mre_r[63:0];
    mim_mag_r <= mim_r[65] ? n_mim[63:0] : mim_r[63:0];
    dre_mag_r <= dre_r[65] ? n_dre[63:0] : dre_r[63:0];
    dim_mag_r <= dim_r[65] ? n_dim[63:0] : dim_r[63:0];
    sq3_r     <= sq2_r;
    dz3_r     <= (sq2_r == 64'd0);
  end

  // stage 4 logic: finish multiply, check whether the quotient fits
  pay_t        pay4;
  logic [32:0] m_re, m_im;

  assign m_re = sat_sm(mre_neg_r, mre_mag_r >> FRAC_BITS);
  assign m_im = sat_sm(mim_neg_r, mim_mag_r >> FRAC_BITS);

  always_comb begin
    pay4.kind   = kind3_r;
    pay4.fin    = fin3_r;
    pay4.re_neg = dre_neg_r;
    pay4.im_neg = dim_neg_r;
    pay4.big_re = (dre_mag_r >> (32 - FRAC_BITS)) >= sq3_r;
    pay4.big_im = (dim_mag_r >> (32 - FRAC_BITS)) >= sq3_r;
    pay4.dz     = dz3_r;
    if (kind3_r == K_MUL) begin
      pay4.fin.re  = m_re[31:0];
      pay4.fin.im  = m_im[31:0];
      pay4.fin.ovf = m_re[32] | m_im[32];
    end
  end

  logic        iv;
  pay_t        ipay;
  logic [31:0] q_re, q_im, root;

  cna_iter u_iter (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (v3_r),
    .in_pay    (pay4),
    .in_num_re (dre_mag_r),
    .in_num_im (dim_mag_r),
    .in_den    (sq3_r),
    .out_vld   (iv),
    .out_pay   (ipay),
    .out_q_re  (q_re),
    .out_q_im  (q_im),
    .out_root  (root)
  );

  // output stage
  logic [32:0] d_re, d_im, r_sq;
  fin_t        res;

  assign d_re = sat_sm(ipay.re_neg, {31'd0, ipay.big_re, q_re});
  assign d_im = sat_sm(ipay.im_neg, {31'd0, ipay.big_im, q_im});
  assign r_sq = sat_sm(1'b0, {32'd0, root});

  always_comb begin
    res = ipay.fin;
    if (ipay.kind == K_DIV) begin
      if (ipay.dz) begin
        res = '0;
      end else begin
        res.re  = d_re[31:0];
        res.im  = d_im[31:0];
        res.eq  = 1'b0;
        res.ovf = d_re[32] | d_im[32];
      end
    end else if (ipay.kind == K_MOD) begin
      res.re  = r_sq[31:0];
      res.im  = '0;
      res.eq  = 1'b0;
      res.ovf = r_sq[32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= iv;
    end
    out_res_real <= res.re;
    out_res_imag <= res.im;
    out_is_equal <= res.eq;
    out_overflow <= res.ovf;
    out_div_zero <= (ipay.kind == K_DIV) & ipay.dz;
  end

endmodule

/* design/cna_iter.sv */
module cna_iter import cna_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  pay_t        in_pay,
  input  logic [63:0] in_num_re,
  input  logic [63:0] in_num_im,
  input  logic [63:0] in_den,
  output logic        out_vld,
  output pay_t        out_pay,
  output logic [31:0] out_q_re,
  output logic [31:0] out_q_im,
  output logic [31:0] out_root
);

  logic            vld_r  [0:QB];
  pay_t            pay_r  [0:QB];
  logic [63:0]     nre_r  [0:QB];
  logic [63:0]     nim_r  [0:QB];
  logic [63:0]     den_r  [0:QB];
  logic [63:0]     rre_r  [0:QB];
  logic [63:0]     rim_r  [0:QB];
  logic [31:0]     qre_r  [0:QB];
  logic [31:0]     qim_r  [0:QB];
  logic [31:0]     root_r [0:QB];
  logic [SQ_W-1:0] srem_r [0:QB];

  // entry stage: partial remainder starts with the numerator's upper bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    pay_r[0]  <= in_pay;
    nre_r[0]  <= in_num_re;
    nim_r[0]  <= in_num_im;
    den_r[0]  <= in_den;
    rre_r[0]  <= in_num_re >> (32 - FRAC_BITS);
    rim_r[0]  <= in_num_im >> (32 - FRAC_BITS);
    qre_r[0]  <= '0;
    qim_r[0]  <= '0;
    root_r[0] <= '0;
    srem_r[0] <= '0;
  end

  genvar k;
  for (k = 0; k < QB; k++) begin : g_stg
    localparam int I = QB - 1 - k;
    logic            bre, bim;
    logic [64:0]     tre, tim, dext;
    logic            gre, gim;
    logic [SQ_W-1:0] st, trial;
    logic            sge;

    if (I >= FRAC_BITS) begin : g_bit
      assign bre = nre_r[k][I-FRAC_BITS];
      assign bim = nim_r[k][I-FRAC_BITS];
    end else begin : g_zero
      assign bre = 1'b0;
      assign bim = 1'b0;
    end

    assign dext  = {1'b0, den_r[k]};
    assign tre   = {rre_r[k], bre};
    assign tim   = {rim_r[k], bim};
    assign gre   = tre >= dext;
    assign gim   = tim >= dext;
    assign st    = {srem_r[k][SQ_W-3:0], den_r[k][2*I+1:2*I]};
    assign trial = {{(SQ_W-34){1'b0}}, root_r[k], 2'b01};
    assign sge   = st >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      pay_r[k+1]  <= pay_r[k];
      nre_r[k+1]  <= nre_r[k];
      nim_r[k+1]  <= nim_r[k];
      den_r[k+1]  <= den_r[k];
      rre_r[k+1]  <= gre ? 64'(tre - dext) : tre[63:0];
      rim_r[k+1]  <= gim ? 64'(tim - dext) : tim[63:0];
      qre_r[k+1]  <= {qre_r[k][30:0], gre};
      qim_r[k+1]  <= {qim_r[k][30:0], gim};
      root_r[k+1] <= {root_r[k][30:0], sge};
      srem_r[k+1] <= sge ? (st - trial) : st;
    end
  end

  assign out_vld  = vld_r[QB];
  assign out_pay  = pay_r[QB];
  assign out_q_re = qre_r[QB];
  assign out_q_im = qim_r[QB];
  assign out_root = root_r[QB];

endmodule

/* tb/testbench.sv */
module testbench;
  import cna_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        eq;
    logic        dz;
    logic        ovf;
  } alu_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_kind = '0;
  logic signed [31:0] in_a_real = '0, in_a_imag = '0, in_b_real = '0, in_b_imag = '0;
  logic out_valid;
  logic signed [31:0] out_res_real, out_res_imag;
  logic out_is_equal, out_div_zero, out_overflow;

  alu_res_t pending_q[$];
  int errors = 0;
  longint cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  complex_number_alu_core dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // signed value of a product or sum, wide enough for any operand
  function automatic logic signed [129:0] ext(input logic [31:0] v);
    return 130'(signed'(v));
  endfunction

  function automatic logic [31:0] clamp(input logic signed [129:0] v, inout logic ovf);
    if (v > 130'sh7FFF_FFFF) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -130'sh8000_0000) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // truncate toward zero
  function automatic logic signed [129:0] tdiv(input logic signed [129:0] n,
                                              input logic signed [129:0] d);
    logic signed [129:0] q;
    q = (n < 0 ? -n : n) / d;
    return n < 0 ? -q : q;
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [127:0] t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic alu_res_t compute_alu(input logic [2:0] k, input logic [31:0] ar,
      input logic [31:0] ai, input logic [31:0] br, input logic [31:0] bi);
    alu_res_t r;
    logic signed [129:0] re, im, den, mr, mi;
    r = '{default: '0};
    mr = ext(ar) < 0 ? -ext(ar) : ext(ar);
    mi = ext(ai) < 0 ? -ext(ai) : ext(ai);
    case (k)
      K_ADD: begin
        r.re = clamp(ext(ar) + ext(br), r.ovf);
        r.im = clamp(ext(ai) + ext(bi), r.ovf);
      end
      K_SUB: begin
        r.re = clamp(ext(ar) - ext(br), r.ovf);
        r.im = clamp(ext(ai) - ext(bi), r.ovf);
      end
      K_MUL: begin
        re = ext(ar) * ext(br) - ext(ai) * ext(bi);
        im = ext(ar) * ext(bi) + ext(ai) * ext(br);
        r.re = clamp(tdiv(re, 130'sd1 << FRAC_BITS), r.ovf);
        r.im = clamp(tdiv(im, 130'sd1 << FRAC_BITS), r.ovf);
      end
      K_DIV: begin
        den = ext(br) * ext(br) + ext(bi) * ext(bi);
        if (den == 0) r.dz = 1'b1;
        else begin
          re = ext(ar) * ext(br) + ext(ai) * ext(bi);
          im = ext(ai) * ext(br) - ext(ar) * ext(bi);
          r.re = clamp(tdiv(re <<< FRAC_BITS, den), r.ovf);
          r.im = clamp(tdiv(im <<< FRAC_BITS, den), r.ovf);
        end
      end
      K_MOD: r.re = clamp(130'(isqrt(64'(mr * mr + mi * mi))), r.ovf);
      K_CONJ: begin
        r.re = ar;
        r.im = clamp(-ext(ai), r.ovf);
      end
      K_CMP: r.eq = (ar == br) && (ai == bi);
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    alu_res_t e;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing pending");
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_res_real !== e.re) begin
          $error("res_real exp %h got %h", e.re, out_res_real); errors++;
        end
        if (out_res_imag !== e.im) begin
          $error("res_imag exp %h got %h", e.im, out_res_imag); errors++;
        end
        if (out_is_equal !== e.eq) begin
          $error("is_equal exp %b got %b", e.eq, out_is_equal); errors++;
        end
        if (out_div_zero !== e.dz) begin
          $error("div_zero exp %b got %b", e.dz, out_div_zero); errors++;
        end
        if (out_overflow !== e.ovf) begin
          $error("overflow exp %b got %b", e.ovf, out_overflow); errors++;
        end
      end
    end
  end

  task automatic send_item(input logic [2:0] k, input logic [31:0] ar, input logic [31:0] ai,
                           input logic [31:0] br, input logic [31:0] bi);
    start <= 1'b1;
    in_kind <= k;
    in_a_real <= ar;
    in_a_imag <= ai;
    in_b_real <= br;
    in_b_imag <= bi;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(compute_alu(k, ar, ai, br, bi));
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 8)) << 16;
      3: return 32'(signed'(16'($urandom)));
      4: return 32'(signed'(24'($urandom)));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] mx, mn, one;
    mx = 32'h7FFF_FFFF; mn = 32'h8000_0000; one = 32'h0001_0000;
    send_item(K_ADD, mx, mn, one, mn);
    send_item(K_ADD, mn, mx, mn, one);
    send_item(K_SUB, mn, mx, one, mn);
    send_item(K_SUB, one, 32'hFFFF_0000, mx, mx);
    send_item(K_MUL, mx, mx, mx, mn);
    send_item(K_MUL, mn, mn, mn, mn);
    send_item(K_MUL, 32'h0002_0000, 32'hFFFF_8000, one, 32'h0000_0003);
    send_item(K_DIV, one, one, 0, 0);
    send_item(K_DIV, mx, mn, 0, 1);
    send_item(K_DIV, 32'h0003_0000, 32'hFFFE_0000, one, one);
    send_item(K_DIV, mn, mn, mn, mn);
    send_item(K_MOD, mn, mn, 0, 0);
    send_item(K_MOD, 32'h0003_0000, 32'h0004_0000, 0, 0);
    send_item(K_MOD, 0, 0, 0, 0);
    send_item(K_CONJ, mn, mn, 0, 0);
    send_item(K_CONJ, mx, 0, 0, 0);
    send_item(K_CMP, mx, mn, mx, mn);
    send_item(K_CMP, mx, mn, mx, mx);
    send_item(K_CMP, 0, 0, 0, 0);
    send_item(3'd7, mx, mn, mx, mn);
  endtask

  task automatic test_random();
    logic [2:0] k;
    logic [31:0] ar, ai;
    repeat (1650) begin
      k = 3'($urandom_range(0, 7));
      ar = rand_part();
      ai = rand_part();
      if (k == K_CMP && $urandom_range(0, 1)) send_item(k, ar, ai, ar, ai);
      else if (k == K_DIV && $urandom_range(0, 9) == 0) send_item(k, ar, ai, 0, 0);
      else send_item(k, ar, ai, rand_part(), rand_part());
      if ($urandom_range(0, 2) == 0) idle_gap();
    end
    start <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

/* sim.f */
design/cna_pkg.sv
design/cna_iter.sv
design/complex_number_alu_core.sv
tb/testbench.sv
